### src/sbp_pkg.sv
// Shared types and constants for the serial byte packetizer.
// Holds the item structs, operation and result codes, and the sequencer states.
// No dependencies.
package sbp_pkg;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned PKT_LEN_W = 7;
  localparam int unsigned TIMER_W   = 8;

  localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_DONE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

  localparam logic [TIMER_W-1:0] IDLE_TIMEOUT_RESET = 8'd10;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [BYTE_W-1:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [BYTE_W-1:0]    data;
    logic                 last;
    logic [PKT_LEN_W-1:0] packet_length;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHOW
  } state_t;

endpackage

### src/sbp_store.sv
// Packet byte store: one write port, one read port, registered read data.
// Uses sbp_pkg for the byte width.
module sbp_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [sbp_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [sbp_pkg::BYTE_W-1:0] rd_data
);

  logic [sbp_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [sbp_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/sbp_ctrl.sv
// Packetizer control: fill count, channel and timer state, packet sequencer,
// result register. Uses sbp_pkg; drives the ports of sbp_store.
module sbp_ctrl #(
  parameter int unsigned PACKET_BYTES = 64,
  parameter int unsigned AW           = 6,
  parameter int unsigned CW           = 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sbp_pkg::TIMER_W-1:0] timeout,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sbp_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sbp_pkg::out_item_t          out_item,
  output logic                        mem_wr_en,
  output logic [AW-1:0]               mem_wr_addr,
  output logic [sbp_pkg::BYTE_W-1:0]  mem_wr_data,
  output logic                        mem_rd_en,
  output logic [AW-1:0]               mem_rd_addr,
  input  logic [sbp_pkg::BYTE_W-1:0]  mem_rd_data
);

  sbp_pkg::state_t             state_r, state_nxt;
  logic [CW-1:0]               fill_r, fill_nxt;
  logic [CW-1:0]               len_r, len_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        chan_free_r, chan_free_nxt;
  logic                        empty_due_r, empty_due_nxt;
  logic                        armed_r, armed_nxt;
  logic [sbp_pkg::TIMER_W-1:0] remain_r, remain_nxt;
  logic                        out_valid_r, out_valid_nxt;
  sbp_pkg::out_item_t          out_r, out_nxt;

  logic out_free;
  logic accept;
  logic is_byte;
  logic is_tick;
  logic expire;
  logic fills;
  logic stream;
  logic idx_last;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == sbp_pkg::ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign is_byte  = in_item.operation == sbp_pkg::OP_BYTE;
  assign is_tick  = in_item.operation == sbp_pkg::OP_TICK;
  assign expire   = is_tick && armed_r && (remain_r == '0);
  assign fills    = is_byte && chan_free_r && (fill_r == CW'(PACKET_BYTES - 1));
  assign stream   = fills || (expire && (fill_r != '0));
  assign idx_last = (idx_r + CW'(1)) == len_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbp_pkg::ST_IDLE: begin
        if (accept && stream) begin
          state_nxt = sbp_pkg::ST_READ;
        end
      end
      sbp_pkg::ST_READ: begin
        state_nxt = sbp_pkg::ST_SHOW;
      end
      sbp_pkg::ST_SHOW: begin
        if (out_free) begin
          state_nxt = idx_last ? sbp_pkg::ST_IDLE : sbp_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = sbp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    chan_free_nxt = chan_free_r;
    empty_due_nxt = empty_due_r;
    armed_nxt     = armed_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = fill_r[AW-1:0];
    mem_wr_data   = in_item.byte_value;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = idx_r[AW-1:0];
    case (state_r)
      sbp_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_item.operation)
            sbp_pkg::OP_BYTE: begin
              if (!chan_free_r) begin
                out_valid_nxt = 1'b1;
                out_nxt.kind          = sbp_pkg::KIND_REFUSED;
                out_nxt.data          = '0;
                out_nxt.last          = 1'b1;
                out_nxt.packet_length = '0;
              end else begin
                mem_wr_en  = 1'b1;
                fill_nxt   = fill_r + CW'(1);
                armed_nxt  = 1'b1;
                remain_nxt = timeout;
                if (fills) begin
                  chan_free_nxt = 1'b0;
                  empty_due_nxt = 1'b1;
                  fill_nxt      = '0;
                  len_nxt       = CW'(PACKET_BYTES);
                  idx_nxt       = '0;
                end
              end
            end
            sbp_pkg::OP_TICK: begin
              if (armed_r) begin
                if (remain_r != '0) begin
                  remain_nxt = remain_r - sbp_pkg::TIMER_W'(1);
                end else begin
                  armed_nxt = 1'b0;
                  if (empty_due_r || (fill_r != '0)) begin
                    chan_free_nxt = 1'b0;
                    empty_due_nxt = 1'b0;
                    fill_nxt      = '0;
                    len_nxt       = fill_r;
                    idx_nxt       = '0;
                    if (fill_r == '0) begin
                      out_valid_nxt = 1'b1;
                      out_nxt.kind          = sbp_pkg::KIND_EMPTY;
                      out_nxt.data          = '0;
                      out_nxt.last          = 1'b1;
                      out_nxt.packet_length = '0;
                    end
                  end
                end
              end
            end
            sbp_pkg::OP_DONE: begin
              chan_free_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      sbp_pkg::ST_READ: begin
        mem_rd_en = 1'b1;
      end
      sbp_pkg::ST_SHOW: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.kind          = sbp_pkg::KIND_BYTE;
          out_nxt.data          = mem_rd_data;
          out_nxt.last          = idx_last;
          out_nxt.packet_length = sbp_pkg::PKT_LEN_W'(len_r);
          idx_nxt               = idx_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbp_pkg::ST_IDLE;
      fill_r      <= '0;
      chan_free_r <= 1'b1;
      empty_due_r <= 1'b0;
      armed_r     <= 1'b0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      chan_free_r <= chan_free_nxt;
      empty_due_r <= empty_due_nxt;
      armed_r     <= armed_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### src/serial_byte_packetizer_idle_flush.sv
// A refused or empty-packet item shows in the cycle after it is taken.
// A packet of N bytes streams from the byte store a byte at a time: read in
// ST_READ, then registered as a result in ST_SHOW. Throughput: one item per
// cycle while no packet streams and no result stalls; else input stalls.
// Reset: synchronous, active low; clears control state, timeout returns to 10.
// Store contents are not cleared; only written entries are read.
module serial_byte_packetizer_idle_flush #(
  parameter int unsigned PACKET_BYTES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [sbp_pkg::TIMER_W-1:0]        cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sbp_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sbp_pkg::out_item_t                 out_item
);

  localparam int unsigned AW = $clog2(PACKET_BYTES);
  localparam int unsigned CW = $clog2(PACKET_BYTES + 1);

  logic [sbp_pkg::TIMER_W-1:0] timeout_r;
  logic                        mem_wr_en;
  logic [AW-1:0]               mem_wr_addr;
  logic [sbp_pkg::BYTE_W-1:0]  mem_wr_data;
  logic                        mem_rd_en;
  logic [AW-1:0]               mem_rd_addr;
  logic [sbp_pkg::BYTE_W-1:0]  mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= sbp_pkg::IDLE_TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  sbp_ctrl #(
    .PACKET_BYTES(PACKET_BYTES),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .timeout    (timeout_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  sbp_store #(
    .DEPTH(PACKET_BYTES),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule

### src/sbp_checker.sv
// Port-level checks for the packetizer top level, attached by bind.
// Uses sbp_pkg for item types and result codes.
module sbp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input sbp_pkg::out_item_t          out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind != sbp_pkg::KIND_BYTE) |-> out_item.last)
    else $error("refused or empty result without last");

  a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind != sbp_pkg::KIND_BYTE)
      |-> (out_item.data == '0) && (out_item.packet_length == '0))
    else $error("refused or empty result carries data or length");

  a_stream_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_item.kind == sbp_pkg::KIND_BYTE) && !out_item.last
      |=> !in_ready)
    else $error("input taken in the middle of a packet");

endmodule

bind serial_byte_packetizer_idle_flush sbp_checker u_sbp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

### tb/sv/testbench.sv
// Testbench for serial_byte_packetizer_idle_flush. A directed table, then random traffic over
// several idle timeouts, with every result checked against an in-bench packetizer model or the table.
// Depends on sbp_pkg and the packetizer RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned PKT_BYTES      = 64;
  localparam int unsigned PKT_AW         = $clog2(PKT_BYTES);
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 22;
  localparam int unsigned N_PHASES       = 6;
  localparam int unsigned N_DIR          = 27;
  localparam logic [sbp_pkg::OP_W-1:0] OP_NOP = 2'd3;
  localparam sbp_pkg::out_item_t WANT_REFUSED = '{sbp_pkg::KIND_REFUSED, 8'h00, 1'b1, 7'd0};
  localparam sbp_pkg::out_item_t WANT_EMPTY   = '{sbp_pkg::KIND_EMPTY, 8'h00, 1'b1, 7'd0};

  typedef struct {
    bit                          is_cfg;
    logic [sbp_pkg::OP_W-1:0]    op;
    logic [7:0]                  val;
    int unsigned                 reps;
    bit                          step;
    bit                          typed;
    bit                          has_want;
    sbp_pkg::out_item_t          want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_wr_en;
  logic [sbp_pkg::TIMER_W-1:0] cfg_wr_data;
  logic      in_valid;
  logic      in_ready;
  sbp_pkg::in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  sbp_pkg::out_item_t out_item;

  // packetizer model state
  logic [7:0]                    pkt_store [PKT_BYTES];
  logic [sbp_pkg::PKT_LEN_W-1:0] pkt_fill;
  bit                            link_free;
  bit                            zlp_due;
  bit                            idle_armed;
  logic [sbp_pkg::TIMER_W-1:0]   idle_left;
  logic [sbp_pkg::TIMER_W-1:0]   idle_limit;

  sbp_pkg::out_item_t out_due_q [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned idle_mode;
  bit          hold_req;
  bit          hold_taken;
  int unsigned hold_left;

  logic [sbp_pkg::TIMER_W-1:0] phase_timeouts [N_PHASES] =
    '{8'd0, 8'd3, 8'd1, 8'd255, 8'd7, 8'd2};

  dir_row_t dir_rows [N_DIR] = '{
    '{1'b0, sbp_pkg::OP_DONE, 8'h00, 1,   1'b0, 1'b1, 1'b0, '0},
    '{1'b0, OP_NOP,           8'hFF, 1,   1'b0, 1'b1, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_TICK, 8'h00, 1,   1'b0, 1'b1, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_BYTE, 8'h00, 1,   1'b0, 1'b1, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_BYTE, 8'hFF, 1,   1'b0, 1'b1, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_TICK, 8'h00, 10,  1'b0, 1'b1, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_TICK, 8'h00, 1,   1'b0, 1'b0, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_BYTE, 8'h5A, 1,   1'b0, 1'b1, 1'b1, WANT_REFUSED},
    '{1'b0, sbp_pkg::OP_TICK, 8'h00, 1,   1'b0, 1'b1, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_DONE, 8'h00, 1,   1'b0, 1'b1, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_BYTE, 8'h00, 64,  1'b1, 1'b0, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_BYTE, 8'h80, 1,   1'b0, 1'b1, 1'b1, WANT_REFUSED},
    '{1'b0, sbp_pkg::OP_TICK, 8'h00, 10,  1'b0, 1'b1, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_TICK, 8'h00, 1,   1'b0, 1'b1, 1'b1, WANT_EMPTY},
    '{1'b0, sbp_pkg::OP_DONE, 8'h00, 1,   1'b0, 1'b1, 1'b0, '0},
    '{1'b1, sbp_pkg::OP_BYTE, 8'd0,  1,   1'b0, 1'b0, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_BYTE, 8'h33, 1,   1'b0, 1'b0, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_TICK, 8'h00, 1,   1'b0, 1'b0, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_DONE, 8'h00, 1,   1'b0, 1'b1, 1'b0, '0},
    '{1'b1, sbp_pkg::OP_BYTE, 8'd20, 1,   1'b0, 1'b0, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_BYTE, 8'h77, 1,   1'b0, 1'b0, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_TICK, 8'h00, 21,  1'b0, 1'b0, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_DONE, 8'h00, 1,   1'b0, 1'b1, 1'b0, '0},
    '{1'b1, sbp_pkg::OP_BYTE, 8'd1,  1,   1'b0, 1'b0, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_BYTE, 8'h01, 1,   1'b0, 1'b0, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_TICK, 8'h00, 2,   1'b0, 1'b0, 1'b0, '0},
    '{1'b0, sbp_pkg::OP_DONE, 8'h00, 1,   1'b0, 1'b1, 1'b0, '0}
  };

  serial_byte_packetizer_idle_flush #(
    .PACKET_BYTES(PKT_BYTES)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void flush_packet(input bit keep);
    sbp_pkg::out_item_t r;
    logic [sbp_pkg::PKT_LEN_W-1:0] len;
    len = pkt_fill;
    link_free = 1'b0;
    zlp_due = (len == sbp_pkg::PKT_LEN_W'(PKT_BYTES));
    if (len == 0) begin
      r.kind = sbp_pkg::KIND_EMPTY;
      r.data = '0;
      r.last = 1'b1;
      r.packet_length = '0;
      if (keep) out_due_q.push_back(r);
    end else begin
      for (int unsigned i = 0; i < len; i++) begin
        r.kind = sbp_pkg::KIND_BYTE;
        r.data = pkt_store[i[PKT_AW-1:0]];
        r.last = (i + 1 == len);
        r.packet_length = len;
        if (keep) out_due_q.push_back(r);
      end
    end
    pkt_fill = '0;
  endfunction

  function automatic void packetize(input sbp_pkg::in_item_t it, input bit keep);
    sbp_pkg::out_item_t r;
    case (it.operation)
      sbp_pkg::OP_BYTE: begin
        if (!link_free) begin
          r.kind = sbp_pkg::KIND_REFUSED;
          r.data = '0;
          r.last = 1'b1;
          r.packet_length = '0;
          if (keep) out_due_q.push_back(r);
        end else begin
          if (pkt_fill < PKT_BYTES) begin
            pkt_store[pkt_fill[PKT_AW-1:0]] = it.byte_value;
            pkt_fill = pkt_fill + 1'b1;
          end
          idle_armed = 1'b1;
          idle_left = idle_limit;
          if (pkt_fill >= PKT_BYTES) flush_packet(keep);
        end
      end
      sbp_pkg::OP_TICK: begin
        if (idle_armed) begin
          if (idle_left != 0) begin
            idle_left = idle_left - 1'b1;
          end else begin
            idle_armed = 1'b0;
            if (zlp_due || pkt_fill != 0) flush_packet(keep);
          end
        end
      end
      sbp_pkg::OP_DONE: link_free = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic bit sender_gap();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 8;
      1: return $urandom_range(0, 99) < 70;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_gap();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 70;
      1: return $urandom_range(0, 99) < 8;
      default: return 1'b0;
    endcase
  endfunction

  task automatic offer(input sbp_pkg::in_item_t it, input bit keep);
    @(negedge clk);
    if (sender_gap()) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (sender_gap());
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    packetize(it, keep);
  endtask

  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (out_due_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_timeout(input logic [sbp_pkg::TIMER_W-1:0] v);
    drain_outputs();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    idle_limit = v;
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned run_len;
    sbp_pkg::in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if (link_free && $urandom_range(0, 99) < 40) run_len = PKT_BYTES - pkt_fill;
        else if (link_free) run_len = $urandom_range(1, 10);
        else run_len = $urandom_range(1, 4);
        if (run_len > n_items - sent) run_len = n_items - sent;
        repeat (run_len) begin
          it.operation = sbp_pkg::OP_BYTE;
          it.byte_value = 8'($urandom_range(0, 255));
          offer(it, 1'b1);
        end
        sent += run_len;
      end else if (pick < 75) begin
        run_len = $urandom_range(1, (idle_limit > 28) ? 30 : idle_limit + 2);
        if (run_len > n_items - sent) run_len = n_items - sent;
        it.operation = sbp_pkg::OP_TICK;
        it.byte_value = 8'($urandom_range(0, 255));
        repeat (run_len) offer(it, 1'b1);
        sent += run_len;
      end else if (pick < 92) begin
        it.operation = sbp_pkg::OP_DONE;
        it.byte_value = 8'($urandom_range(0, 255));
        offer(it, 1'b1);
        sent++;
      end else begin
        it.operation = sbp_pkg::OP_W'($urandom_range(0, 3));
        it.byte_value = 8'($urandom_range(0, 255));
        offer(it, 1'b1);
        if (it.operation != OP_NOP) sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !receiver_gap();
    end
  end

  always @(posedge clk) begin : check_results
    sbp_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (out_due_q.size() == 0) begin
        mismatches++;
        $display("%0t: expected none, got kind=%0d data=%02h last=%0d len=%0d", $time,
                 out_item.kind, out_item.data, out_item.last, out_item.packet_length);
      end else begin
        want = out_due_q.pop_front();
        if (out_item.kind !== want.kind || out_item.data !== want.data ||
            out_item.last !== want.last || out_item.packet_length !== want.packet_length) begin
          mismatches++;
          $display("%0t: kind/data/last/len expected %0d/%02h/%0d/%0d, got %0d/%02h/%0d/%0d",
                   $time, want.kind, want.data, want.last, want.packet_length,
                   out_item.kind, out_item.data, out_item.last, out_item.packet_length);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    sbp_pkg::in_item_t it;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    hold_req = 1'b0;
    hold_taken = 1'b0;
    hold_left = 0;
    mismatches = 0;
    quiet_cycles = 0;
    idle_mode = 0;
    pkt_fill = '0;
    link_free = 1'b1;
    zlp_due = 1'b0;
    idle_armed = 1'b0;
    idle_left = '0;
    idle_limit = sbp_pkg::IDLE_TIMEOUT_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        set_timeout(dir_rows[r].val);
      end else begin
        for (int unsigned k = 0; k < dir_rows[r].reps; k++) begin
          it.operation = dir_rows[r].op;
          it.byte_value = dir_rows[r].step ? dir_rows[r].val + k[7:0] : dir_rows[r].val;
          offer(it, !dir_rows[r].typed);
          if (dir_rows[r].typed && dir_rows[r].has_want) out_due_q.push_back(dir_rows[r].want);
        end
      end
    end

    for (int unsigned p = 0; p < N_PHASES; p++) begin
      set_timeout(phase_timeouts[p]);
      idle_mode = p / 2;
      if (p == 4) begin
        hold_req <= 1'b1;
        it.operation = sbp_pkg::OP_DONE;
        it.byte_value = 8'h00;
        offer(it, 1'b1);
        repeat (PKT_BYTES) begin
          it.operation = sbp_pkg::OP_BYTE;
          it.byte_value = 8'($urandom_range(0, 255));
          offer(it, 1'b1);
        end
      end
      run_phase(PHASE_ITEMS);
    end

    drain_outputs();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && out_due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
